@@ rtl/bta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_pkg
// Shared widths, codes and types of the boundary-tag first-fit allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

    localparam int OPCODE_W    = 2;
    localparam int BYTES_W     = 16;
    localparam int BLOCK_W     = 10;
    localparam int BLOCKS_W    = 11;
    localparam int STATUS_W    = 2;
    localparam int SURPLUS_W   = 5;
    localparam int BLOCK_SHIFT = 4;
    localparam int NEED_W      = BYTES_W - BLOCK_SHIFT + 1;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;

    localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_INIT  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BLOCKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPLIT   = 1'd1;

    localparam logic [BLOCKS_W-1:0]  HEAP_BLOCKS_RST = 11'd1024;
    localparam logic [SURPLUS_W-1:0] MIN_SPLIT_RST   = 5'd4;

    typedef struct packed {
        logic [BLOCKS_W-1:0]  heap_blocks;
        logic [SURPLUS_W-1:0] min_split;
    } t_cfg;

endpackage

@@ rtl/bta_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_if
// Valid/ready channels: request, result and configuration write.
// ----------------------------------------------------------------------------
interface bta_req_if;
    logic                          valid;
    logic                          ready;
    logic [bta_pkg::OPCODE_W-1:0]  opcode;
    logic [bta_pkg::BYTES_W-1:0]   request_bytes;
    logic [bta_pkg::BLOCK_W-1:0]   free_block;

    modport source (output valid, opcode, request_bytes, free_block, input ready);
    modport sink   (input valid, opcode, request_bytes, free_block, output ready);
endinterface

interface bta_res_if;
    logic                          valid;
    logic                          ready;
    logic [bta_pkg::STATUS_W-1:0]  status;
    logic [bta_pkg::BLOCK_W-1:0]   start_block;
    logic [bta_pkg::BLOCKS_W-1:0]  blocks_granted;

    modport source (output valid, status, start_block, blocks_granted, input ready);
    modport sink   (input valid, status, start_block, blocks_granted, output ready);
endinterface

interface bta_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bta_pkg::CFG_IDX_W-1:0]   index;
    logic [bta_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/bta_tag_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_tag_mem
// Tag store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bta_tag_mem #(
    parameter int DEPTH = 1024,
    parameter int DW    = 12
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/bta_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bta_ctrl
// Sequencer: walks header tags, splits, merges and formats the heap.
// ----------------------------------------------------------------------------
module bta_ctrl #(
    parameter int HEAP_BLOCKS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bta_pkg::t_cfg                      i_cfg,
    bta_req_if.sink                            i_req,
    bta_res_if.source                          o_res,
    output logic                               o_hdr_we,
    output logic [$clog2(HEAP_BLOCKS)-1:0]     o_hdr_waddr,
    output logic [$clog2(HEAP_BLOCKS+1):0]     o_hdr_wdata,
    output logic [$clog2(HEAP_BLOCKS)-1:0]     o_hdr_raddr,
    input  logic [$clog2(HEAP_BLOCKS+1):0]     i_hdr_rdata,
    output logic                               o_ftr_we,
    output logic [$clog2(HEAP_BLOCKS)-1:0]     o_ftr_waddr,
    output logic [$clog2(HEAP_BLOCKS+1):0]     o_ftr_wdata,
    output logic [$clog2(HEAP_BLOCKS)-1:0]     o_ftr_raddr,
    input  logic [$clog2(HEAP_BLOCKS+1):0]     i_ftr_rdata
);

    localparam int AW = $clog2(HEAP_BLOCKS);
    localparam int SW = $clog2(HEAP_BLOCKS + 1);
    localparam int TW = SW + 1;
    localparam int XW = ((SW > bta_pkg::NEED_W) ? SW : bta_pkg::NEED_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FMT,
        S_WALK,
        S_SPLIT,
        S_FREE_A,
        S_FREE_B,
        S_RESULT
    } t_state;

    t_state                        r_state, n_state;
    logic                          r_report, n_report;
    logic [AW-1:0]                 r_pos, n_pos;
    logic [AW-1:0]                 r_blk, n_blk;
    logic [SW-1:0]                 r_avail, n_avail;
    logic [SW-1:0]                 r_heap_end, n_heap_end;
    logic [bta_pkg::NEED_W-1:0]    r_need, n_need;
    logic [TW-1:0]                 r_tag, n_tag;
    logic [TW-1:0]                 r_prev, n_prev;
    logic [bta_pkg::STATUS_W-1:0]  r_res_status, n_res_status;
    logic [bta_pkg::BLOCK_W-1:0]   r_res_start, n_res_start;
    logic [bta_pkg::BLOCKS_W-1:0]  r_res_blocks, n_res_blocks;
    logic                          r_out_valid, n_out_valid;
    logic [bta_pkg::STATUS_W-1:0]  r_out_status, n_out_status;
    logic [bta_pkg::BLOCK_W-1:0]   r_out_start, n_out_start;
    logic [bta_pkg::BLOCKS_W-1:0]  r_out_blocks, n_out_blocks;

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out_status;
    assign o_res.start_block    = r_out_start;
    assign o_res.blocks_granted = r_out_blocks;

    always_comb begin
        logic [XW-1:0] hb_x;
        logic [XW-1:0] fmt_x;
        logic [XW-1:0] end_x;
        logic [XW-1:0] pos_x;
        logic [XW-1:0] blk_x;
        logic [XW-1:0] size_x;
        logic [XW-1:0] need_x;
        logic [XW-1:0] surplus_x;
        logic [XW-1:0] split_x;
        logic [XW-1:0] next_x;
        logic [XW-1:0] start_x;
        logic [XW-1:0] total_x;
        logic [XW-1:0] prev_x;
        logic [XW-1:0] nbr_x;
        logic [XW-1:0] tail_x;
        logic [bta_pkg::NEED_W-1:0] need_in;

        n_state      = r_state;
        n_report     = r_report;
        n_pos        = r_pos;
        n_blk        = r_blk;
        n_avail      = r_avail;
        n_heap_end   = r_heap_end;
        n_need       = r_need;
        n_tag        = r_tag;
        n_prev       = r_prev;
        n_res_status = r_res_status;
        n_res_start  = r_res_start;
        n_res_blocks = r_res_blocks;
        n_out_valid  = r_out_valid && !o_res.ready;
        n_out_status = r_out_status;
        n_out_start  = r_out_start;
        n_out_blocks = r_out_blocks;

        o_hdr_we    = 1'b0;
        o_hdr_waddr = '0;
        o_hdr_wdata = '0;
        o_hdr_raddr = '0;
        o_ftr_we    = 1'b0;
        o_ftr_waddr = '0;
        o_ftr_wdata = '0;
        o_ftr_raddr = '0;

        hb_x   = XW'(i_cfg.heap_blocks);
        fmt_x  = (hb_x < XW'(2)) ? XW'(2) :
                 (hb_x > XW'(HEAP_BLOCKS)) ? XW'(HEAP_BLOCKS) : hb_x;
        end_x  = XW'(r_heap_end);
        pos_x  = XW'(r_pos);
        blk_x  = XW'(r_blk);
        need_x = XW'(r_need);
        size_x = '0;
        surplus_x = '0;
        next_x  = '0;
        start_x = '0;
        total_x = '0;
        prev_x  = '0;
        nbr_x   = '0;
        tail_x  = '0;
        split_x = (i_cfg.min_split == '0) ? XW'(1) : XW'(i_cfg.min_split);
        need_in = bta_pkg::NEED_W'(i_req.request_bytes[bta_pkg::BYTES_W-1:bta_pkg::BLOCK_SHIFT])
                + bta_pkg::NEED_W'(i_req.request_bytes[bta_pkg::BLOCK_SHIFT-1:0] != '0)
                + bta_pkg::NEED_W'(1);

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.opcode)
                        bta_pkg::OP_ALLOC: begin
                            if (i_req.request_bytes == '0) begin
                                n_res_status = bta_pkg::ST_ZERO;
                                n_res_start  = '0;
                                n_res_blocks = '0;
                                n_state      = S_RESULT;
                            end else begin
                                n_need      = need_in;
                                n_pos       = '0;
                                o_hdr_raddr = '0;
                                n_state     = S_WALK;
                            end
                        end
                        bta_pkg::OP_FREE: begin
                            blk_x = XW'(i_req.free_block);
                            if (blk_x >= end_x) begin
                                n_res_status = bta_pkg::ST_OK;
                                n_res_start  = i_req.free_block;
                                n_res_blocks = '0;
                                n_state      = S_RESULT;
                            end else begin
                                n_blk       = blk_x[AW-1:0];
                                o_hdr_raddr = blk_x[AW-1:0];
                                o_ftr_raddr = blk_x[AW-1:0] - AW'(1);
                                n_state     = S_FREE_A;
                            end
                        end
                        bta_pkg::OP_INIT: begin
                            n_report = 1'b1;
                            n_state  = S_FMT;
                        end
                        default: begin
                            n_res_status = bta_pkg::ST_OK;
                            n_res_start  = '0;
                            n_res_blocks = '0;
                            n_state      = S_RESULT;
                        end
                    endcase
                end
            end
            S_FMT: begin
                o_hdr_we    = 1'b1;
                o_hdr_waddr = '0;
                o_hdr_wdata = {fmt_x[SW-1:0], 1'b0};
                o_ftr_we    = 1'b1;
                tail_x      = fmt_x - XW'(1);
                o_ftr_waddr = tail_x[AW-1:0];
                o_ftr_wdata = {fmt_x[SW-1:0], 1'b0};
                n_heap_end  = fmt_x[SW-1:0];
                n_res_status = bta_pkg::ST_OK;
                n_res_start  = '0;
                n_res_blocks = fmt_x[bta_pkg::BLOCKS_W-1:0];
                n_state      = r_report ? S_RESULT : S_IDLE;
                n_report     = 1'b0;
            end
            S_WALK: begin
                size_x    = XW'(i_hdr_rdata[TW-1:1]);
                surplus_x = size_x - need_x;
                next_x    = pos_x + size_x;
                n_res_start  = pos_x[bta_pkg::BLOCK_W-1:0];
                n_res_status = bta_pkg::ST_OK;
                if (size_x == '0 || size_x > end_x - pos_x) begin
                    n_res_status = bta_pkg::ST_NOFIT;
                    n_res_start  = '0;
                    n_res_blocks = '0;
                    n_state      = S_RESULT;
                end else if (!i_hdr_rdata[0] && size_x >= need_x) begin
                    o_hdr_we    = 1'b1;
                    o_hdr_waddr = r_pos;
                    o_ftr_we    = 1'b1;
                    if (surplus_x < split_x) begin
                        tail_x       = next_x - XW'(1);
                        o_hdr_wdata  = {size_x[SW-1:0], 1'b1};
                        o_ftr_waddr  = tail_x[AW-1:0];
                        o_ftr_wdata  = {size_x[SW-1:0], 1'b1};
                        n_res_blocks = size_x[bta_pkg::BLOCKS_W-1:0];
                        n_state      = S_RESULT;
                    end else begin
                        tail_x       = pos_x + need_x - XW'(1);
                        o_hdr_wdata  = {need_x[SW-1:0], 1'b1};
                        o_ftr_waddr  = tail_x[AW-1:0];
                        o_ftr_wdata  = {need_x[SW-1:0], 1'b1};
                        n_avail      = size_x[SW-1:0];
                        n_res_blocks = need_x[bta_pkg::BLOCKS_W-1:0];
                        n_state      = S_SPLIT;
                    end
                end else if (next_x >= end_x) begin
                    n_res_status = bta_pkg::ST_NOFIT;
                    n_res_start  = '0;
                    n_res_blocks = '0;
                    n_state      = S_RESULT;
                end else begin
                    o_hdr_raddr = next_x[AW-1:0];
                    n_pos       = next_x[AW-1:0];
                end
            end
            S_SPLIT: begin
                size_x      = XW'(r_avail);
                surplus_x   = size_x - need_x;
                start_x     = pos_x + need_x;
                tail_x      = pos_x + size_x - XW'(1);
                o_hdr_we    = 1'b1;
                o_hdr_waddr = start_x[AW-1:0];
                o_hdr_wdata = {surplus_x[SW-1:0], 1'b0};
                o_ftr_we    = 1'b1;
                o_ftr_waddr = tail_x[AW-1:0];
                o_ftr_wdata = {surplus_x[SW-1:0], 1'b0};
                n_state     = S_RESULT;
            end
            S_FREE_A: begin
                size_x = XW'(i_hdr_rdata[TW-1:1]);
                next_x = blk_x + size_x;
                if (size_x == '0 || size_x > end_x - blk_x) begin
                    n_res_status = bta_pkg::ST_OK;
                    n_res_start  = blk_x[bta_pkg::BLOCK_W-1:0];
                    n_res_blocks = '0;
                    n_state      = S_RESULT;
                end else begin
                    tail_x      = next_x - XW'(1);
                    o_ftr_raddr = tail_x[AW-1:0];
                    o_hdr_raddr = next_x[AW-1:0];
                    n_tag       = i_hdr_rdata;
                    n_prev      = i_ftr_rdata;
                    n_state     = S_FREE_B;
                end
            end
            S_FREE_B: begin
                size_x  = XW'(r_tag[TW-1:1]);
                next_x  = blk_x + size_x;
                prev_x  = XW'(r_prev[TW-1:1]);
                nbr_x   = XW'(i_hdr_rdata[TW-1:1]);
                start_x = blk_x;
                total_x = size_x;
                if (i_ftr_rdata != r_tag) begin
                    n_res_status = bta_pkg::ST_OK;
                    n_res_start  = blk_x[bta_pkg::BLOCK_W-1:0];
                    n_res_blocks = '0;
                end else begin
                    if (blk_x != '0 && !r_prev[0] && prev_x != '0 && prev_x <= blk_x) begin
                        start_x = blk_x - prev_x;
                        total_x = total_x + prev_x;
                    end
                    if (next_x < end_x && !i_hdr_rdata[0] && nbr_x != '0
                            && nbr_x <= end_x - next_x) begin
                        total_x = total_x + nbr_x;
                    end
                    tail_x      = start_x + total_x - XW'(1);
                    o_hdr_we    = 1'b1;
                    o_hdr_waddr = start_x[AW-1:0];
                    o_hdr_wdata = {total_x[SW-1:0], 1'b0};
                    o_ftr_we    = 1'b1;
                    o_ftr_waddr = tail_x[AW-1:0];
                    o_ftr_wdata = {total_x[SW-1:0], 1'b0};
                    n_res_status = bta_pkg::ST_OK;
                    n_res_start  = start_x[bta_pkg::BLOCK_W-1:0];
                    n_res_blocks = total_x[bta_pkg::BLOCKS_W-1:0];
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_start  = r_res_start;
                    n_out_blocks = r_res_blocks;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FMT;
            r_report    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_report    <= n_report;
            r_out_valid <= n_out_valid;
        end
        r_pos        <= n_pos;
        r_blk        <= n_blk;
        r_avail      <= n_avail;
        r_heap_end   <= n_heap_end;
        r_need       <= n_need;
        r_tag        <= n_tag;
        r_prev       <= n_prev;
        r_res_status <= n_res_status;
        r_res_start  <= n_res_start;
        r_res_blocks <= n_res_blocks;
        r_out_status <= n_out_status;
        r_out_start  <= n_out_start;
        r_out_blocks <= n_out_blocks;
    end

endmodule

@@ rtl/boundary_tag_first_fit_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator
// First-fit heap allocator over header and footer tag memories.
// ----------------------------------------------------------------------------
// Steps: allocate walks the regions from block 0 and, when the region is split,
// writes the remainder tags in a further state; free reads the region's tags and
// its neighbours' tags, then writes the merged region.
// Throughput: one request at a time; the walk reads one header tag per cycle.
// Reset: synchronous; the cycle after reset formats the heap as one free
// region and no request is taken in that cycle.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator #(
    parameter int HEAP_BLOCKS = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bta_req_if.sink    i_req,
    bta_res_if.source  o_res,
    bta_cfg_if.sink    i_cfg
);

    localparam int AW = $clog2(HEAP_BLOCKS);
    localparam int TW = $clog2(HEAP_BLOCKS + 1) + 1;

    bta_pkg::t_cfg  r_cfg;
    logic           hdr_we, ftr_we;
    logic [AW-1:0]  hdr_waddr, hdr_raddr, ftr_waddr, ftr_raddr;
    logic [TW-1:0]  hdr_wdata, hdr_rdata, ftr_wdata, ftr_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heap_blocks <= bta_pkg::HEAP_BLOCKS_RST;
            r_cfg.min_split   <= bta_pkg::MIN_SPLIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                bta_pkg::REG_HEAP_BLOCKS: begin
                    r_cfg.heap_blocks <= i_cfg.data;
                end
                bta_pkg::REG_MIN_SPLIT: begin
                    r_cfg.min_split <= i_cfg.data[bta_pkg::SURPLUS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    bta_tag_mem #(
        .DEPTH (HEAP_BLOCKS),
        .DW    (TW)
    ) u_hdr_mem (
        .i_clk   (i_clk),
        .i_we    (hdr_we),
        .i_waddr (hdr_waddr),
        .i_wdata (hdr_wdata),
        .i_raddr (hdr_raddr),
        .o_rdata (hdr_rdata)
    );

    bta_tag_mem #(
        .DEPTH (HEAP_BLOCKS),
        .DW    (TW)
    ) u_ftr_mem (
        .i_clk   (i_clk),
        .i_we    (ftr_we),
        .i_waddr (ftr_waddr),
        .i_wdata (ftr_wdata),
        .i_raddr (ftr_raddr),
        .o_rdata (ftr_rdata)
    );

    bta_ctrl #(
        .HEAP_BLOCKS (HEAP_BLOCKS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req       (i_req),
        .o_res       (o_res),
        .o_hdr_we    (hdr_we),
        .o_hdr_waddr (hdr_waddr),
        .o_hdr_wdata (hdr_wdata),
        .o_hdr_raddr (hdr_raddr),
        .i_hdr_rdata (hdr_rdata),
        .o_ftr_we    (ftr_we),
        .o_ftr_waddr (ftr_waddr),
        .o_ftr_wdata (ftr_wdata),
        .o_ftr_raddr (ftr_raddr),
        .i_ftr_rdata (ftr_rdata)
    );

`ifndef NO_ASSERTIONS
    a_tag_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hdr_we |-> (ftr_we && hdr_wdata == ftr_wdata))
        else $error("header and footer tags written apart");

    a_tag_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hdr_we |-> (hdr_wdata[TW-1:1] != '0))
        else $error("zero-size tag written");

    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second request taken while one is in flight");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status != bta_pkg::ST_OK)
            |-> (o_res.start_block == '0 && o_res.blocks_granted == '0))
        else $error("failed allocate carries a region");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the boundary-tag first-fit allocator against a shadow heap of header
// and footer tags. Directed requests cover the heap limits, the split threshold
// and stale tags. Random phases follow under several configurations, with
// random stalls on both sides and one long result hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HEAP_SIZE    = 1024;
    localparam int TAG_W        = bta_pkg::BLOCKS_W + 1;
    localparam int BLOCK_BYTES  = 1 << bta_pkg::BLOCK_SHIFT;
    localparam int MAX_IDLE     = 10;
    localparam int HOLD_OFF     = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 120;

    localparam logic [bta_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [bta_pkg::OPCODE_W-1:0] op;
        logic [bta_pkg::BYTES_W-1:0]  bytes;
        logic [bta_pkg::BLOCK_W-1:0]  blk;
    } t_heap_req;

    typedef struct {
        logic [bta_pkg::STATUS_W-1:0] status;
        logic [bta_pkg::BLOCK_W-1:0]  start;
        logic [bta_pkg::BLOCKS_W-1:0] blocks;
    } t_grant;

    logic i_clk;
    logic i_rst_n;

    bta_req_if req_if();
    bta_res_if res_if();
    bta_cfg_if cfg_if();

    boundary_tag_first_fit_allocator #(
        .HEAP_BLOCKS(HEAP_SIZE)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    logic [TAG_W-1:0]              hdr_tag [HEAP_SIZE];
    logic [TAG_W-1:0]              ftr_tag [HEAP_SIZE];
    bit                            hdr_set [HEAP_SIZE];
    bit                            ftr_set [HEAP_SIZE];
    int                            heap_end;
    logic [bta_pkg::BLOCKS_W-1:0]  cfg_heap_blocks = bta_pkg::HEAP_BLOCKS_RST;
    logic [bta_pkg::SURPLUS_W-1:0] cfg_min_split   = bta_pkg::MIN_SPLIT_RST;

    t_grant grants_due [$];
    int     granted_starts [$];
    t_grant due;
    int     mismatches      = 0;
    int     cycle_count     = 0;
    bit     src_idle        = 1'b1;
    bit     sink_idle       = 1'b1;
    int     hold_off_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int tag_size(logic [TAG_W-1:0] t);
        return int'(t[TAG_W-1:1]);
    endfunction

    function automatic void set_region(int start, int size, bit used);
        logic [TAG_W-1:0] t;
        t = TAG_W'((size << 1) | used);
        hdr_tag[start]          = t;
        ftr_tag[start + size - 1] = t;
        hdr_set[start]          = 1'b1;
        ftr_set[start + size - 1] = 1'b1;
    endfunction

    function automatic void format_heap();
        int n;
        n = int'(cfg_heap_blocks);
        if (n < 2) n = 2;
        if (n > HEAP_SIZE) n = HEAP_SIZE;
        heap_end = n;
        set_region(0, n, 1'b0);
    endfunction

    function automatic int blocks_needed(logic [bta_pkg::BYTES_W-1:0] bytes);
        return ((int'(bytes) + BLOCK_BYTES - 1) >> bta_pkg::BLOCK_SHIFT) + 1;
    endfunction

    function automatic t_grant make_grant(logic [bta_pkg::STATUS_W-1:0] st, int start,
                                          int blocks);
        t_grant g;
        g.status = st;
        g.start  = bta_pkg::BLOCK_W'(start);
        g.blocks = bta_pkg::BLOCKS_W'(blocks);
        return g;
    endfunction

    // Apply one request to the shadow heap and return the grant it yields.
    function automatic t_grant predict_grant(t_heap_req r);
        t_grant           g;
        logic [TAG_W-1:0] t;
        int               need, split, pos, avail, blk, n, p, m, start, total;
        g = make_grant(bta_pkg::ST_OK, 0, 0);
        case (r.op)
            bta_pkg::OP_ALLOC: begin
                if (r.bytes == '0) begin
                    g = make_grant(bta_pkg::ST_ZERO, 0, 0);
                end else begin
                    need  = blocks_needed(r.bytes);
                    split = (cfg_min_split == '0) ? 1 : int'(cfg_min_split);
                    g     = make_grant(bta_pkg::ST_NOFIT, 0, 0);
                    pos   = 0;
                    while (pos < heap_end) begin
                        t     = hdr_tag[pos];
                        avail = tag_size(t);
                        if (avail == 0 || avail > heap_end - pos) break;
                        if (!t[0] && avail >= need) begin
                            if (avail - need < split) begin
                                set_region(pos, avail, 1'b1);
                                g = make_grant(bta_pkg::ST_OK, pos, avail);
                            end else begin
                                set_region(pos, need, 1'b1);
                                set_region(pos + need, avail - need, 1'b0);
                                g = make_grant(bta_pkg::ST_OK, pos, need);
                            end
                            granted_starts.push_back(pos);
                            if (granted_starts.size() > 64) void'(granted_starts.pop_front());
                            break;
                        end
                        pos += avail;
                    end
                end
            end
            bta_pkg::OP_FREE: begin
                blk = int'(r.blk);
                g   = make_grant(bta_pkg::ST_OK, blk, 0);
                if (blk < heap_end) begin
                    t = hdr_tag[blk];
                    n = tag_size(t);
                    if (n != 0 && n <= heap_end - blk && ftr_tag[blk + n - 1] == t) begin
                        start = blk;
                        total = n;
                        if (blk > 0) begin
                            p = tag_size(ftr_tag[blk - 1]);
                            if (!ftr_tag[blk - 1][0] && p != 0 && p <= blk) begin
                                start = blk - p;
                                total += p;
                            end
                        end
                        if (blk + n < heap_end) begin
                            m = tag_size(hdr_tag[blk + n]);
                            if (!hdr_tag[blk + n][0] && m != 0 && m <= heap_end - (blk + n))
                                total += m;
                        end
                        set_region(start, total, 1'b0);
                        g = make_grant(bta_pkg::ST_OK, start, total);
                    end
                end
            end
            bta_pkg::OP_INIT: begin
                format_heap();
                g = make_grant(bta_pkg::ST_OK, 0, heap_end);
            end
            default: ;
        endcase
        return g;
    endfunction

    // True when the request reads only tags that were written since reset.
    function automatic bit reads_known(t_heap_req r);
        int need, pos, avail, blk, n;
        if (r.op == bta_pkg::OP_ALLOC && r.bytes != '0) begin
            need = blocks_needed(r.bytes);
            pos  = 0;
            while (pos < heap_end) begin
                if (!hdr_set[pos]) return 1'b0;
                avail = tag_size(hdr_tag[pos]);
                if (avail == 0 || avail > heap_end - pos) return 1'b1;
                if (!hdr_tag[pos][0] && avail >= need) return 1'b1;
                pos += avail;
            end
        end else if (r.op == bta_pkg::OP_FREE) begin
            blk = int'(r.blk);
            if (blk >= heap_end) return 1'b1;
            if (!hdr_set[blk]) return 1'b0;
            n = tag_size(hdr_tag[blk]);
            if (n == 0 || n > heap_end - blk) return 1'b1;
            if (!ftr_set[blk + n - 1]) return 1'b0;
            if (ftr_tag[blk + n - 1] != hdr_tag[blk]) return 1'b1;
            if (blk > 0 && !ftr_set[blk - 1]) return 1'b0;
            if (blk + n < heap_end && !hdr_set[blk + n]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int pick_used();
        int pos, avail;
        int starts [$];
        pos = 0;
        while (pos < heap_end && hdr_set[pos]) begin
            avail = tag_size(hdr_tag[pos]);
            if (avail == 0 || avail > heap_end - pos) break;
            if (hdr_tag[pos][0]) starts.push_back(pos);
            pos += avail;
        end
        if (starts.size() == 0) return -1;
        return starts[$urandom_range(0, starts.size() - 1)];
    endfunction

    function automatic logic [bta_pkg::BYTES_W-1:0] random_bytes();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)  return '0;
        if (roll < 65) return bta_pkg::BYTES_W'($urandom_range(1, 128));
        if (roll < 90) return bta_pkg::BYTES_W'($urandom_range(1, heap_end * 4));
        return bta_pkg::BYTES_W'($urandom);
    endfunction

    function automatic t_heap_req random_request();
        t_heap_req r;
        int        roll, pick;
        r.op    = bta_pkg::OP_ALLOC;
        r.bytes = bta_pkg::BYTES_W'($urandom);
        r.blk   = bta_pkg::BLOCK_W'($urandom);
        roll    = $urandom_range(0, 99);
        if (roll < 48) begin
            r.bytes = random_bytes();
        end else if (roll < 88) begin
            pick = pick_used();
            if (pick >= 0) begin
                r.op  = bta_pkg::OP_FREE;
                r.blk = bta_pkg::BLOCK_W'(pick);
            end else begin
                r.bytes = random_bytes();
            end
        end else if (roll < 93 && granted_starts.size() > 0) begin
            r.op  = bta_pkg::OP_FREE;
            r.blk = bta_pkg::BLOCK_W'(
                granted_starts[$urandom_range(0, granted_starts.size() - 1)]);
        end else if (roll < 96) begin
            r.op = bta_pkg::OP_FREE;
        end else if (roll < 98) begin
            r.op = bta_pkg::OP_INIT;
        end else begin
            r.op = OP_UNUSED;
        end
        if (!reads_known(r)) r.op = bta_pkg::OP_INIT;
        return r;
    endfunction

    task automatic send_request(t_heap_req r);
        int gap;
        gap = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.opcode        <= r.op;
        req_if.request_bytes <= r.bytes;
        req_if.free_block    <= r.blk;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        grants_due.push_back(predict_grant(r));
    endtask

    task automatic request(logic [bta_pkg::OPCODE_W-1:0] op, int bytes, int blk);
        t_heap_req r;
        r.op    = op;
        r.bytes = bta_pkg::BYTES_W'(bytes);
        r.blk   = bta_pkg::BLOCK_W'(blk);
        send_request(r);
    endtask

    task automatic wait_drain();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (grants_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_config(logic [bta_pkg::CFG_DATA_W-1:0] heap,
                                logic [bta_pkg::CFG_DATA_W-1:0] split);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= bta_pkg::REG_HEAP_BLOCKS;
        cfg_if.data  <= heap;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_heap_blocks = heap[bta_pkg::BLOCKS_W-1:0];
        cfg_if.index <= bta_pkg::REG_MIN_SPLIT;
        cfg_if.data  <= split;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_min_split = split[bta_pkg::SURPLUS_W-1:0];
        cfg_if.valid <= 1'b0;
    endtask

    task automatic test_directed_ops();
        request(bta_pkg::OP_ALLOC, 0, 0);
        request(bta_pkg::OP_ALLOC, 65535, 0);
        request(bta_pkg::OP_ALLOC, 1, 0);
        request(bta_pkg::OP_ALLOC, 16, 0);
        request(bta_pkg::OP_ALLOC, 17, 0);
        request(OP_UNUSED, 65535, 1023);
        request(bta_pkg::OP_FREE, 0, 2);
        request(bta_pkg::OP_FREE, 0, 0);
        request(bta_pkg::OP_FREE, 0, 2);
        request(bta_pkg::OP_FREE, 0, 4);
        request(bta_pkg::OP_ALLOC, 16368, 0);
    endtask

    task automatic test_heap_size_limits();
        wait_drain();
        write_config(1, 0);
        request(bta_pkg::OP_INIT, 0, 0);
        request(bta_pkg::OP_ALLOC, 1, 0);
        request(bta_pkg::OP_FREE, 0, 1000);
        request(bta_pkg::OP_FREE, 0, 0);
    endtask

    task automatic test_split_threshold();
        wait_drain();
        write_config(2047, 16);
        request(bta_pkg::OP_INIT, 0, 0);
        request(bta_pkg::OP_ALLOC, 16128, 0);
        request(bta_pkg::OP_INIT, 0, 0);
        request(bta_pkg::OP_ALLOC, 16112, 0);
    endtask

    task automatic test_stale_tags();
        wait_drain();
        write_config(1024, 4);
        request(bta_pkg::OP_INIT, 0, 0);
        repeat (3) request(bta_pkg::OP_ALLOC, 48, 0);
        request(bta_pkg::OP_FREE, 0, 0);
        wait_drain();
        write_config(16, 4);
        request(bta_pkg::OP_INIT, 0, 0);
        request(bta_pkg::OP_FREE, 0, 4);
        request(bta_pkg::OP_ALLOC, 130, 0);
        request(bta_pkg::OP_FREE, 0, 8);
    endtask

    task automatic test_random_traffic();
        int heap, split;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin heap = 1024; split = 4;  end
                1: begin heap = 2;    split = 1;  end
                2: begin heap = 64;   split = 16; end
                3: begin heap = 1024; split = 1;  end
                default: begin
                    heap  = ($urandom_range(0, 99) < 15) ? $urandom_range(0, 2047)
                                                         : $urandom_range(2, 1024);
                    split = $urandom_range(0, 16);
                end
            endcase
            wait_drain();
            write_config(bta_pkg::CFG_DATA_W'(heap), bta_pkg::CFG_DATA_W'(split));
            src_idle  = (ph != 3);
            sink_idle = (ph != 3);
            request(bta_pkg::OP_INIT, $urandom, $urandom);
            repeat (PHASE_ITEMS) send_request(random_request());
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    task automatic test_receiver_holdoff();
        wait_drain();
        src_idle        = 1'b0;
        hold_off_cycles = HOLD_OFF;
        repeat (30) send_request(random_request());
        wait_drain();
        src_idle = 1'b1;
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.opcode        <= bta_pkg::OP_ALLOC;
        req_if.request_bytes <= '0;
        req_if.free_block    <= '0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= bta_pkg::REG_HEAP_BLOCKS;
        cfg_if.data          <= '0;
        format_heap();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_ops();
        test_heap_size_limits();
        test_split_threshold();
        test_stale_tags();
        test_random_traffic();
        test_receiver_holdoff();
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        int stall;
        res_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_off_cycles > 0) begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (res_if.valid !== 1'b1);
        end
    end

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t mismatch %s expected %0d actual %0d", $realtime, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (grants_due.size() == 0) begin
                mismatches++;
                $display("%0t unexpected grant: expected none, actual %0d %0d %0d",
                         $realtime, res_if.status, res_if.start_block,
                         res_if.blocks_granted);
            end else begin
                due = grants_due.pop_front();
                check_field("status", 16'(due.status), 16'(res_if.status));
                check_field("start_block", 16'(due.start), 16'(res_if.start_block));
                check_field("blocks_granted", 16'(due.blocks), 16'(res_if.blocks_granted));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

endmodule

@@ boundary_tag_first_fit_allocator.f @@
rtl/bta_pkg.sv
rtl/bta_if.sv
rtl/bta_tag_mem.sv
rtl/bta_ctrl.sv
rtl/boundary_tag_first_fit_allocator.sv
tb/testbench.sv
